FILE: rtl/core/m68k_effective_address_unit_defines.svh
// ----------------------------------------------------------------------------
// m68k effective address unit assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef M68K_EFFECTIVE_ADDRESS_UNIT_DEFINES_SVH
`define M68K_EFFECTIVE_ADDRESS_UNIT_DEFINES_SVH

`ifndef SYNTH
`define M68K_EAU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define M68K_EAU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define M68K_EAU_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define M68K_EAU_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/core/m68k_eau_pkg.sv
// ----------------------------------------------------------------------------
// m68k effective address unit package
// Shared constants, request/result/pending/register-write types and the index scaling helper.
// ----------------------------------------------------------------------------
package m68k_eau_pkg;

    localparam int REG_COUNT = 16;

    localparam logic [4:0] NO_INDEX = 5'd16;

    // request kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_CALC   = 2'd1;
    localparam logic [1:0] KIND_RETURN = 2'd2;

    // addressing modes
    localparam logic [2:0] MODE_AIND    = 3'd2;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;
    localparam logic [2:0] MODE_DISP    = 3'd5;
    localparam logic [2:0] MODE_INDEX   = 3'd6;
    localparam logic [2:0] MODE_SPECIAL = 3'd7;

    // mode 7 register field
    localparam logic [2:0] SPEC_ABS_SHORT = 3'd0;
    localparam logic [2:0] SPEC_ABS_LONG  = 3'd1;
    localparam logic [2:0] SPEC_PC_DISP   = 3'd2;
    localparam logic [2:0] SPEC_PC_INDEX  = 3'd3;

    // full format fields
    localparam logic [1:0] BD_RESERVED  = 2'd0;
    localparam logic [1:0] BD_NULL      = 2'd1;
    localparam logic [2:0] IIS_NONE     = 3'd0;
    localparam logic [2:0] IIS_RESERVED = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  write_index;
        logic [31:0] data_value;
        logic [2:0]  ea_mode;
        logic [2:0]  ea_register;
        logic [2:0]  operand_bytes;
        logic [31:0] instr_address;
        logic [2:0]  ext_offset;
        logic [15:0] ext_word;
        logic [31:0] base_disp;
        logic [31:0] outer_disp;
    } req_t;

    typedef struct packed {
        logic [31:0] address;
        logic        program_space;
        logic        indirect_read;
        logic        fault;
    } result_t;

    typedef struct packed {
        logic        ind;
        logic [4:0]  sel;
        logic        idx_long;
        logic [1:0]  scale;
        logic [31:0] od;
    } pend_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    function automatic logic [31:0] index_value(logic [31:0] v, logic is_long,
                                                logic [1:0] scale);
        logic [31:0] x;
        x = is_long ? v : {{16{v[15]}}, v[15:0]};
        return x << scale;
    endfunction

endpackage

FILE: rtl/core/m68k_eau_regfile.sv
// ----------------------------------------------------------------------------
// m68k effective address unit register file
// D0-D7/A0-A7 store: one write port, two registered write-first read ports,
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module m68k_eau_regfile
    import m68k_eau_pkg::*;
#(
    parameter int DEPTH = REG_COUNT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [31:0]   rd_data_a,
    output logic [31:0]   rd_data_b
);

    logic [31:0]      ram [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      rd_a_reg;
    logic [31:0]      rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // write-first: same-edge write is forwarded to the read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && wr_addr == rd_addr_a) begin
                rd_a_reg <= wr_data;
            end else begin
                rd_a_reg <= valid_reg[rd_addr_a] ? ram[rd_addr_a] : '0;
            end
            if (wr_en && wr_addr == rd_addr_b) begin
                rd_b_reg <= wr_data;
            end else begin
                rd_b_reg <= valid_reg[rd_addr_b] ? ram[rd_addr_b] : '0;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: rtl/core/m68k_eau_calc.sv
// ----------------------------------------------------------------------------
// m68k effective address unit address calculation
// Decodes one request against register data and pending indirection state;
// produces the result, the register file write and the next pending state.
// ----------------------------------------------------------------------------
module m68k_eau_calc
    import m68k_eau_pkg::*;
(
    input  req_t        req,
    input  logic        cpu_model,
    input  logic [31:0] base_data,
    input  logic [31:0] index_data,
    input  pend_t       pend,
    output result_t     result,
    output rf_wr_t      rf_wr,
    output pend_t       pend_next
);

    always_comb begin
        logic        size_bad;
        logic [2:0]  step;
        logic [31:0] pc_adj;
        logic [31:0] base;
        logic [31:0] bd;
        logic [31:0] idx_scaled;
        logic [31:0] idx;
        logic [31:0] pend_idx;
        logic [1:0]  scale;
        logic [2:0]  iis;
        logic        indexed;
        logic        pc_base;

        result     = '0;
        rf_wr.en   = 1'b0;
        rf_wr.idx  = req.write_index;
        rf_wr.data = req.data_value;
        pend_next  = pend;

        size_bad   = (req.operand_bytes == 3'd3) || (req.operand_bytes > 3'd4);
        step       = (req.ea_register == 3'd7 && req.operand_bytes == 3'd1) ?
                     3'd2 : req.operand_bytes;
        pc_adj     = req.instr_address + {29'b0, req.ext_offset};
        scale      = cpu_model ? req.ext_word[10:9] : 2'b00;
        idx_scaled = index_value(index_data, req.ext_word[11], scale);
        iis        = req.ext_word[2:0];
        bd         = req.base_disp;
        base       = base_data;
        idx        = idx_scaled;
        indexed    = 1'b0;
        pc_base    = 1'b0;
        pend_idx   = pend.sel[4] ? 32'd0 : index_value(index_data, pend.idx_long, pend.scale);

        unique case (req.kind)
            KIND_WRITE: begin
                rf_wr.en = 1'b1;
            end
            KIND_CALC: begin
                pend_next.ind = 1'b0;
                pend_next.sel = NO_INDEX;
                if (size_bad || req.ea_mode < MODE_AIND) begin
                    result.fault = 1'b1;
                end else begin
                    unique case (req.ea_mode)
                        MODE_AIND: begin
                            result.address = base_data;
                        end
                        MODE_POSTINC: begin
                            result.address = base_data;
                            rf_wr.en       = 1'b1;
                            rf_wr.idx      = {1'b1, req.ea_register};
                            rf_wr.data     = base_data + {29'b0, step};
                        end
                        MODE_PREDEC: begin
                            result.address = base_data - {29'b0, step};
                            rf_wr.en       = 1'b1;
                            rf_wr.idx      = {1'b1, req.ea_register};
                            rf_wr.data     = base_data - {29'b0, step};
                        end
                        MODE_DISP: begin
                            result.address = base_data + bd;
                        end
                        MODE_INDEX: begin
                            indexed = 1'b1;
                        end
                        MODE_SPECIAL: begin
                            unique case (req.ea_register)
                                SPEC_ABS_SHORT, SPEC_ABS_LONG: begin
                                    result.address = bd;
                                end
                                SPEC_PC_DISP: begin
                                    result.address       = pc_adj + bd;
                                    result.program_space = 1'b1;
                                end
                                SPEC_PC_INDEX: begin
                                    indexed = 1'b1;
                                    pc_base = 1'b1;
                                end
                                default: begin
                                    result.fault = 1'b1;
                                end
                            endcase
                        end
                        default: begin
                            result.fault = 1'b1;
                        end
                    endcase
                end

                if (indexed) begin
                    base = pc_base ? pc_adj : base_data;
                    if (!req.ext_word[8]) begin
                        // brief format
                        result.address = base + {{24{req.ext_word[7]}}, req.ext_word[7:0]}
                                         + idx_scaled;
                        result.program_space = pc_base;
                    end else if (!cpu_model || req.ext_word[5:4] == BD_RESERVED ||
                                 iis == IIS_RESERVED || (req.ext_word[6] && iis[2])) begin
                        result.fault = 1'b1;
                    end else begin
                        // full format
                        if (req.ext_word[7]) begin
                            base = '0;
                        end
                        if (req.ext_word[5:4] == BD_NULL) begin
                            bd = '0;
                        end
                        if (req.ext_word[6]) begin
                            idx = '0;
                        end
                        result.program_space = pc_base;
                        if (iis[2]) begin
                            result.address = base + bd;
                        end else begin
                            result.address = base + idx + bd;
                        end
                        if (iis != IIS_NONE) begin
                            result.indirect_read = 1'b1;
                            pend_next.ind        = 1'b1;
                            pend_next.sel        = iis[2] ? {1'b0, req.ext_word[15:12]}
                                                          : NO_INDEX;
                            pend_next.idx_long   = req.ext_word[11];
                            pend_next.scale      = scale;
                            pend_next.od         = iis[1] ? req.outer_disp : 32'd0;
                        end
                    end
                end
            end
            KIND_RETURN: begin
                if (pend.ind) begin
                    result.address = req.data_value + pend_idx + pend.od;
                    pend_next.ind  = 1'b0;
                    pend_next.sel  = NO_INDEX;
                end else begin
                    result.fault = 1'b1;
                end
            end
            default: begin
                result.fault = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/m68k_effective_address_unit.sv
// ----------------------------------------------------------------------------
// m68k effective address unit
// Holds D0-D7/A0-A7 and computes 68k effective addresses per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready: write a register (kind 0), compute an
//   address (kind 1) or return the long read at an indirect pointer (kind 2).
//   Each request gives exactly one result on m_valid/m_ready: address,
//   program_space, indirect_read and fault.
//   m_valid rises once the request has passed the input register (with a
//   registered register file read) and then the result register.
//   Throughput is one request per cycle while m_ready is high; any request
//   may follow the one before it directly, since the register file read
//   forwards a same-cycle write and the pending index select is forwarded
//   from the calculation stage.
//   When indirect_read is set the caller reads the long at address and sends
//   it back as a kind 2 request to get the final address.
//   If m_ready is low the result is held and one more request is taken into
//   the input register; s_ready then drops until the result moves.
//   cfg_wr_en/cfg_wr_data write cpu_model (0: 68000/010, 1: 68020/030) and
//   must only be used while idle. Reset clears all registers to zero, drops
//   any pending indirection and sets cpu_model to 0; no warm-up is needed.
// ----------------------------------------------------------------------------
`include "m68k_effective_address_unit_defines.svh"

module m68k_effective_address_unit
    import m68k_eau_pkg::*;
#(
    parameter int REGISTER_COUNT = REG_COUNT
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [3:0]         s_write_index,
    input  logic [31:0]        s_data_value,
    input  logic [2:0]         s_ea_mode,
    input  logic [2:0]         s_ea_register,
    input  logic [2:0]         s_operand_bytes,
    input  logic [31:0]        s_instr_address,
    input  logic [2:0]         s_ext_offset,
    input  logic [15:0]        s_ext_word,
    input  logic signed [31:0] s_base_disp,
    input  logic signed [31:0] s_outer_disp,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_address,
    output logic               m_program_space,
    output logic               m_indirect_read,
    output logic               m_fault
);

    localparam int RF_AW = $clog2(REGISTER_COUNT);

    req_t             s_req;
    req_t             req_reg;
    logic             in_vld_reg;
    logic             m_vld_reg;
    result_t          result_reg;
    result_t          result_next;
    pend_t            pend_reg;
    pend_t            pend_next;
    rf_wr_t           rf_wr;
    logic             cpu_model_reg;
    logic             accept;
    logic             fire;
    logic [4:0]       pend_sel_fwd;
    logic [RF_AW-1:0] rd_addr_a;
    logic [RF_AW-1:0] rd_addr_b;
    logic [31:0]      base_data;
    logic [31:0]      index_data;

    assign s_req = '{
        kind:          s_kind,
        write_index:   s_write_index,
        data_value:    s_data_value,
        ea_mode:       s_ea_mode,
        ea_register:   s_ea_register,
        operand_bytes: s_operand_bytes,
        instr_address: s_instr_address,
        ext_offset:    s_ext_offset,
        ext_word:      s_ext_word,
        base_disp:     s_base_disp,
        outer_disp:    s_outer_disp
    };

    assign fire    = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || !m_vld_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // pending select as it stands after the request now in calculation
    assign pend_sel_fwd = fire ? pend_next.sel : pend_reg.sel;
    assign rd_addr_a    = RF_AW'({1'b1, s_ea_register});
    assign rd_addr_b    = (s_kind == KIND_RETURN) ? RF_AW'(pend_sel_fwd[3:0])
                                                  : RF_AW'(s_ext_word[15:12]);

    m68k_eau_regfile #(
        .DEPTH (REGISTER_COUNT)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (fire && rf_wr.en),
        .wr_addr   (RF_AW'(rf_wr.idx)),
        .wr_data   (rf_wr.data),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (base_data),
        .rd_data_b (index_data)
    );

    m68k_eau_calc u_calc (
        .req        (req_reg),
        .cpu_model  (cpu_model_reg),
        .base_data  (base_data),
        .index_data (index_data),
        .pend       (pend_reg),
        .result     (result_next),
        .rf_wr      (rf_wr),
        .pend_next  (pend_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_model_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            cpu_model_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (accept) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (fire) begin
            m_vld_reg <= 1'b1;
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '{ind: 1'b0, sel: NO_INDEX, idx_long: 1'b0, scale: 2'b00, od: 32'd0};
        end else if (fire) begin
            pend_reg <= pend_next;
        end
    end

    assign m_valid         = m_vld_reg;
    assign m_address       = result_reg.address;
    assign m_program_space = result_reg.program_space;
    assign m_indirect_read = result_reg.indirect_read;
    assign m_fault         = result_reg.fault;

    `M68K_EAU_ASSERT_IMP(a_fault_clean, aclk, aresetn, m_vld_reg && result_reg.fault, result_reg.address == 32'd0 && !result_reg.program_space && !result_reg.indirect_read, "fault result carries nonzero fields")
    `M68K_EAU_ASSERT_IMP(a_sel_needs_pend, aclk, aresetn, pend_reg.sel != NO_INDEX, pend_reg.ind, "post-index select without pending indirection")
    `M68K_EAU_ASSERT_IMP(a_sel_range, aclk, aresetn, pend_reg.sel[4], pend_reg.sel[3:0] == 4'd0, "pending select out of range")
    `M68K_EAU_ASSERT_IMP(a_ind_pending, aclk, aresetn, m_vld_reg && result_reg.indirect_read, pend_reg.ind, "pointer result shown without pending indirection")
    `M68K_EAU_ASSERT_NXT(a_fire_shows, aclk, aresetn, fire, m_vld_reg, "calculated request did not reach result register")

endmodule
